// File: rtl/qht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature heading tracker package
// Shared types, request codes, sizes and the count-to-angle table.
// ----------------------------------------------------------------------------
package qht_pkg;

  localparam int CountsPerTurn = 448;
  localparam int FractionScale = 10;
  localparam int HalfTurn      = CountsPerTurn / 2;

  // signed count register holds -HalfTurn .. HalfTurn-1
  localparam int CountW    = $clog2(CountsPerTurn);
  localparam int DegW      = 9;
  localparam int ChangeW   = 10;
  localparam int TenthW    = 4;

  // table indexed by count magnitude, 0 .. HalfTurn
  localparam int LutDepth  = HalfTurn + 1;
  localparam int LutIdxW   = $clog2(LutDepth);
  localparam int MagW      = DegW - 1;
  localparam int LutW      = MagW + TenthW;

  localparam int InDataW   = 16;
  localparam int OutDataW  = 48;
  localparam int OpW       = 3;

  typedef enum logic [OpW-1:0] {
    OpPinSample = 3'd0,
    OpRefPulse  = 3'd1,
    OpSpChange  = 3'd2,
    OpSpReset   = 3'd3,
    OpFlagClear = 3'd4
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]            op;
    logic                      pin_a;
    logic                      pin_b;
    logic                      reference_enabled;
    logic signed [ChangeW-1:0] setpoint_change;
  } item_t;

  typedef struct packed {
    logic [1:0]               prev_pins;
    logic signed [CountW-1:0] turn_count;
    logic signed [DegW-1:0]   setpoint;
    logic                     found;
  } state_t;

  typedef struct packed {
    logic signed [CountW-1:0] raw_count;
    logic signed [DegW-1:0]   angle_degrees;
    logic [TenthW-1:0]        angle_tenths;
    logic signed [DegW-1:0]   setpoint_degrees;
    logic signed [DegW-1:0]   error_degrees;
    logic                     reference_found;
  } result_t;

  typedef logic [LutDepth-1:0][LutW-1:0] angle_lut_t;

  // entry: {whole degrees, tenths digit} of magnitude * 360 / CountsPerTurn
  function automatic angle_lut_t build_angle_lut();
    angle_lut_t lut;
    int         t;
    for (int i = 0; i < LutDepth; i++) begin
      t = (i * 360 * FractionScale) / CountsPerTurn;
      lut[i] = {MagW'(t / FractionScale), TenthW'(t % FractionScale)};
    end
    return lut;
  endfunction

  localparam angle_lut_t AngleLut = build_angle_lut();

endpackage

// File: rtl/qht_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature heading tracker step
// Next state and result for one request, from the current tracker state.
// ----------------------------------------------------------------------------
module qht_step (
  input  qht_pkg::item_t   item_i,
  input  qht_pkg::state_t  state_i,
  output qht_pkg::state_t  state_o,
  output qht_pkg::result_t result_o
);
  import qht_pkg::*;

  localparam int SumW = DegW + 2;
  localparam int ErrW = DegW + 1;

  localparam logic signed [SumW-1:0] SpHi     = SumW'(180);
  localparam logic signed [SumW-1:0] SpLo     = -SumW'(180);
  localparam logic signed [SumW-1:0] SpHi2    = SumW'(540);
  localparam logic signed [SumW-1:0] SpLo2    = -SumW'(540);
  localparam logic signed [SumW-1:0] Wrap1    = SumW'(360);
  localparam logic signed [SumW-1:0] Wrap2    = SumW'(720);
  localparam logic signed [ErrW-1:0] ErrHi    = ErrW'(180);
  localparam logic signed [ErrW-1:0] ErrLo    = -ErrW'(180);
  localparam logic signed [ErrW-1:0] ErrWrap  = ErrW'(360);
  localparam logic [CountW:0]        CntTop   = (CountW+1)'(HalfTurn);
  localparam logic [CountW:0]        CntBot   = (CountW+1)'(-HalfTurn - 1);

  logic [1:0]               pins;
  logic                     step_up;
  logic                     step_dn;
  logic signed [CountW:0]   cnt_ext;
  logic signed [CountW:0]   cnt_step;
  logic signed [CountW-1:0] cnt_next;
  logic signed [SumW-1:0]   sp_sum;
  logic signed [DegW-1:0]   sp_wrap;
  state_t                   nxt;
  logic [CountW:0]          mag;
  logic [LutW-1:0]          lut_entry;
  logic signed [DegW-1:0]   angle;
  logic signed [ErrW-1:0]   err;
  logic signed [ErrW-1:0]   err_wrap;

  assign pins = {item_i.pin_b, item_i.pin_a};

  always_comb begin
    step_up = (state_i.prev_pins == 2'b01 && pins == 2'b00) ||
              (state_i.prev_pins == 2'b11 && pins == 2'b01) ||
              (state_i.prev_pins == 2'b00 && pins == 2'b10) ||
              (state_i.prev_pins == 2'b10 && pins == 2'b11);
    step_dn = (state_i.prev_pins == 2'b10 && pins == 2'b00) ||
              (state_i.prev_pins == 2'b00 && pins == 2'b01) ||
              (state_i.prev_pins == 2'b11 && pins == 2'b10) ||
              (state_i.prev_pins == 2'b01 && pins == 2'b11);
    cnt_ext = {state_i.turn_count[CountW-1], state_i.turn_count};
    if (step_up) begin
      cnt_step = cnt_ext + (CountW+1)'(1);
    end else if (step_dn) begin
      cnt_step = cnt_ext - (CountW+1)'(1);
    end else begin
      cnt_step = cnt_ext;
    end
    // wrap at half a turn in either direction
    priority if (cnt_step == CntTop) begin
      cnt_next = CountW'(-HalfTurn);
    end else if (cnt_step == CntBot) begin
      cnt_next = CountW'(HalfTurn - 1);
    end else begin
      cnt_next = cnt_step[CountW-1:0];
    end
  end

  always_comb begin
    sp_sum = SumW'(state_i.setpoint) + SumW'(item_i.setpoint_change);
    priority if (sp_sum > SpHi2) begin
      sp_wrap = DegW'(sp_sum - Wrap2);
    end else if (sp_sum > SpHi) begin
      sp_wrap = DegW'(sp_sum - Wrap1);
    end else if (sp_sum < SpLo2) begin
      sp_wrap = DegW'(sp_sum + Wrap2);
    end else if (sp_sum < SpLo) begin
      sp_wrap = DegW'(sp_sum + Wrap1);
    end else begin
      sp_wrap = sp_sum[DegW-1:0];
    end
  end

  always_comb begin
    nxt = state_i;
    unique case (op_e'(item_i.op))
      OpPinSample: begin
        nxt.turn_count = cnt_next;
        nxt.prev_pins  = pins;
      end
      OpRefPulse: begin
        if (item_i.reference_enabled) begin
          nxt.turn_count = '0;
          nxt.prev_pins  = '0;
          nxt.setpoint   = '0;
          nxt.found      = 1'b1;
        end
      end
      OpSpChange:  nxt.setpoint = sp_wrap;
      OpSpReset:   nxt.setpoint = '0;
      OpFlagClear: nxt.found    = 1'b0;
      default:     nxt = state_i;
    endcase
  end

  assign state_o = nxt;

  // angle by magnitude lookup, sign restored afterwards
  always_comb begin
    mag = nxt.turn_count[CountW-1] ?
          -{nxt.turn_count[CountW-1], nxt.turn_count} :
          {nxt.turn_count[CountW-1], nxt.turn_count};
    lut_entry = AngleLut[mag[LutIdxW-1:0]];
    angle = nxt.turn_count[CountW-1] ?
            -DegW'({1'b0, lut_entry[LutW-1:TenthW]}) :
            DegW'({1'b0, lut_entry[LutW-1:TenthW]});
    err = ErrW'(nxt.setpoint) - ErrW'(angle);
    priority if (err > ErrHi) begin
      err_wrap = err - ErrWrap;
    end else if (err < ErrLo) begin
      err_wrap = err + ErrWrap;
    end else begin
      err_wrap = err;
    end
  end

  always_comb begin
    result_o.raw_count        = nxt.turn_count;
    result_o.angle_degrees    = angle;
    result_o.angle_tenths     = lut_entry[TenthW-1:0];
    result_o.setpoint_degrees = nxt.setpoint;
    result_o.error_degrees    = err_wrap[DegW-1:0];
    result_o.reference_found  = nxt.found;
  end

endmodule

// File: rtl/quadrature_heading_tracker.sv
`timescale 1ns / 1ps
// A request is held in the input register, its result in the result register.
// Throughput: one request per cycle while results are taken; the tracker state
// updates as the request moves from the input register to the result register.
// An empty input register takes a new request while a result waits to be taken.
// Reset clears the count, pin history, setpoint, flag and both valid bits.
// ----------------------------------------------------------------------------
// Quadrature heading tracker
// Quadrature count, heading, setpoint and shortest heading error per request.
// ----------------------------------------------------------------------------
module quadrature_heading_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pin_a, pin_b, reference_enabled, setpoint_change[9:0], zero fill
  input  logic [qht_pkg::InDataW-1:0]   s_axis_tdata_i,
  // operation[2:0]
  input  logic [qht_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // raw_count[8:0], angle_degrees[8:0], angle_tenths[3:0],
  // setpoint_degrees[8:0], error_degrees[8:0], reference_found, zero fill
  output logic [qht_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import qht_pkg::*;

  localparam int ResW = $bits(result_t);

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  state_t  state_q;
  state_t  state_nxt;
  result_t res_nxt;
  logic    advance;
  logic    in_fire;
  logic    process;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign process         = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  qht_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (process) begin
        state_q <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.op                <= s_axis_tuser_i;
      in_item_q.pin_a             <= s_axis_tdata_i[0];
      in_item_q.pin_b             <= s_axis_tdata_i[1];
      in_item_q.reference_enabled <= s_axis_tdata_i[2];
      in_item_q.setpoint_change   <= s_axis_tdata_i[ChangeW+2:3];
    end
    if (process) begin
      out_res_q <= res_nxt;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ResW)'(0),
                            out_res_q.reference_found,
                            out_res_q.error_degrees,
                            out_res_q.setpoint_degrees,
                            out_res_q.angle_tenths,
                            out_res_q.angle_degrees,
                            out_res_q.raw_count};

endmodule

// File: rtl/qht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature heading tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module qht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [qht_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic [qht_pkg::OpW-1:0]       s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [qht_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import qht_pkg::*;

  logic signed [CountW-1:0] raw_count;
  logic [TenthW-1:0]        tenths;
  logic signed [DegW-1:0]   err_deg;
  logic signed [DegW-1:0]   sp_deg;

  assign raw_count = m_axis_tdata_o[8:0];
  assign tenths    = m_axis_tdata_o[21:18];
  assign sp_deg    = m_axis_tdata_o[30:22];
  assign err_deg   = m_axis_tdata_o[39:31];

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  // nothing is offered right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered out of reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> raw_count >= -CountW'(HalfTurn) &&
                        raw_count <= CountW'(HalfTurn - 1))
    else $error("count out of turn range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> tenths < TenthW'(FractionScale))
    else $error("tenths digit out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> err_deg >= -DegW'(180) && err_deg <= DegW'(180) &&
                        sp_deg >= -DegW'(180) && sp_deg <= DegW'(180))
    else $error("setpoint or error outside half a turn");

endmodule

bind quadrature_heading_tracker qht_checker u_qht_checker (.*);

// File: tb/quadrature_heading_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature heading tracker testbench
// Drives pin samples, reference pulses, setpoint, flag-clear and spare requests
// through the stream ports with random gaps and stalls. Every result is checked
// field by field against a heading predictor in the bench or a fixed plan value.
// ----------------------------------------------------------------------------
module quadrature_heading_tracker_tb;
  import qht_pkg::*;

  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  localparam int RandomItems   = 600;
  localparam int CalmAfter     = 520;
  localparam int SqueezeAt     = 150;
  localparam int HoldOffCycles = 80;
  localparam int DrainCycles   = 10;

  localparam result_t AllClear = '0;
  localparam result_t FoundSet = '{reference_found: 1'b1, default: '0};

  typedef struct {
    logic [OpW-1:0]     op;
    bit                 a;
    bit                 b;
    bit                 en;
    logic [ChangeW-1:0] change;
    bit                 fixed;
    result_t            want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // heading tracker mirror
  logic [1:0] trk_pins;
  int         trk_count;
  int         trk_setpoint;
  bit         trk_found;

  result_t heading_q[$];
  int      mismatches;
  bit      calm;
  bit      hold_off;

  plan_row_t plan [24] = '{
    '{OpPinSample, 1'b0, 1'b0, 1'b1, -10'sd1,   1'b1, AllClear},
    '{OpPinSample, 1'b0, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b0, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b0, 1'b0, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b0, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b0, 1'b0, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b0, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpPinSample, 1'b1, 1'b1, 1'b0, 10'sd0,    1'b0, AllClear},
    '{OpSpChange,  1'b1, 1'b1, 1'b1, 10'sd360,  1'b0, AllClear},
    '{OpSpChange,  1'b0, 1'b0, 1'b0, -10'sd360, 1'b0, AllClear},
    '{OpSpChange,  1'b0, 1'b0, 1'b0, 10'sd511,  1'b0, AllClear},
    '{OpSpChange,  1'b0, 1'b0, 1'b0, -10'sd512, 1'b0, AllClear},
    '{OpSpChange,  1'b0, 1'b0, 1'b0, 10'sd180,  1'b0, AllClear},
    '{OpSpChange,  1'b0, 1'b0, 1'b0, 10'sd1,    1'b0, AllClear},
    '{OpSpReset,   1'b1, 1'b1, 1'b1, -10'sd1,   1'b0, AllClear},
    '{OpRefPulse,  1'b1, 1'b1, 1'b0, -10'sd1,   1'b0, AllClear},
    '{OpRefPulse,  1'b1, 1'b1, 1'b1, -10'sd1,   1'b1, FoundSet},
    '{OpFlagClear, 1'b1, 1'b1, 1'b1, -10'sd1,   1'b1, AllClear},
    '{OpSpare5,    1'b1, 1'b1, 1'b1, -10'sd1,   1'b1, AllClear},
    '{OpSpare6,    1'b1, 1'b1, 1'b1, -10'sd1,   1'b1, AllClear},
    '{OpSpare7,    1'b1, 1'b1, 1'b1, -10'sd1,   1'b1, AllClear}
  };

  quadrature_heading_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    // pin_a, pin_b, reference_enabled, setpoint_change[9:0], zero fill
    .s_axis_tdata_i  (s_axis_tdata),
    // operation[2:0]
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    // raw_count, angle_degrees, angle_tenths, setpoint_degrees,
    // error_degrees, reference_found, zero fill
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // forward order of the pin pair {B, A} is 00 -> 10 -> 11 -> 01 -> 00
  function automatic logic [1:0] gray_next(logic [1:0] pins, bit up);
    case (pins)
      2'b00:   return up ? 2'b10 : 2'b01;
      2'b01:   return up ? 2'b00 : 2'b11;
      2'b10:   return up ? 2'b11 : 2'b00;
      default: return up ? 2'b01 : 2'b10;
    endcase
  endfunction

  function automatic result_t advance_heading(logic [OpW-1:0] op, logic [1:0] pins, bit en,
                                              logic signed [ChangeW-1:0] change);
    result_t r;
    int      angle;
    int      tenths;
    int      err;
    case (op)
      OpPinSample: begin
        if (pins == gray_next(trk_pins, 1'b1)) trk_count++;
        else if (pins == gray_next(trk_pins, 1'b0)) trk_count--;
        trk_pins = pins;
        if (trk_count == HalfTurn) trk_count = -HalfTurn;
        else if (trk_count == -HalfTurn - 1) trk_count = HalfTurn - 1;
      end
      OpRefPulse: begin
        if (en) begin
          trk_count    = 0;
          trk_pins     = 2'b00;
          trk_setpoint = 0;
          trk_found    = 1'b1;
        end
      end
      OpSpChange: begin
        trk_setpoint += int'(change);
        while (trk_setpoint > 180) trk_setpoint -= 360;
        while (trk_setpoint < -180) trk_setpoint += 360;
      end
      OpSpReset:   trk_setpoint = 0;
      OpFlagClear: trk_found = 1'b0;
      default: ;
    endcase
    angle  = trk_count * 360 / CountsPerTurn;
    tenths = (trk_count * 360 * FractionScale / CountsPerTurn) % FractionScale;
    if (tenths < 0) tenths = -tenths;
    err = trk_setpoint - angle;
    if (err > 180) err -= 360;
    else if (err < -180) err += 360;
    r.raw_count        = CountW'(trk_count);
    r.angle_degrees    = DegW'(angle);
    r.angle_tenths     = TenthW'(tenths);
    r.setpoint_degrees = DegW'(trk_setpoint);
    r.error_degrees    = DegW'(err);
    r.reference_found  = trk_found;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t: %s", $time, what);
  endtask

  task automatic send_request(logic [OpW-1:0] op, logic [1:0] pins, bit en,
                              logic [ChangeW-1:0] change, bit fixed, result_t want);
    result_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, change, en, pins[1], pins[0]};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_heading(op, pins, en, change);
    heading_q.push_back(fixed ? want : predicted);
  endtask

  always @(posedge clk_i) begin : watch_results
    result_t             exp;
    logic [OutDataW-1:0] want;
    logic [OutDataW-1:0] got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = m_axis_tdata_o;
      if (heading_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", got));
      end else begin
        exp  = heading_q.pop_front();
        want = {7'b0, exp.reference_found, exp.error_degrees, exp.setpoint_degrees,
                exp.angle_tenths, exp.angle_degrees, exp.raw_count};
        if (got[8:0] !== want[8:0])
          report_mismatch($sformatf("raw_count got %0d want %0d",
                                    $signed(got[8:0]), $signed(want[8:0])));
        if (got[17:9] !== want[17:9])
          report_mismatch($sformatf("angle_degrees got %0d want %0d",
                                    $signed(got[17:9]), $signed(want[17:9])));
        if (got[21:18] !== want[21:18])
          report_mismatch($sformatf("angle_tenths got %0d want %0d", got[21:18], want[21:18]));
        if (got[30:22] !== want[30:22])
          report_mismatch($sformatf("setpoint_degrees got %0d want %0d",
                                    $signed(got[30:22]), $signed(want[30:22])));
        if (got[39:31] !== want[39:31])
          report_mismatch($sformatf("error_degrees got %0d want %0d",
                                    $signed(got[39:31]), $signed(want[39:31])));
        if (got[40] !== want[40])
          report_mismatch($sformatf("reference_found got %b want %b", got[40], want[40]));
        if (got[47:41] !== want[47:41])
          report_mismatch($sformatf("zero fill got %h", got[47:41]));
      end
    end
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int         items;
    int         run_len;
    bit         up;
    bit         squeezed;
    logic [1:0] pins;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpPinSample;
    trk_pins      = 2'b00;
    trk_count     = 0;
    trk_setpoint  = 0;
    trk_found     = 1'b0;
    mismatches    = 0;
    calm          = 1'b0;
    hold_off      = 1'b0;
    squeezed      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      send_request(plan[i].op, {plan[i].b, plan[i].a}, plan[i].en, plan[i].change,
                   plan[i].fixed, plan[i].want);

    items = 0;
    while (items < RandomItems) begin
      if (items >= CalmAfter) calm = 1'b1;
      if (items >= SqueezeAt && !squeezed) begin
        hold_off = 1'b1;
        squeezed = 1'b1;
      end
      // open with a sweep long enough to cross the half-turn wrap
      if (items == 0) run_len = $urandom_range(280, 300);
      else if ($urandom_range(0, 9) < 7) run_len = $urandom_range(1, 120);
      else run_len = 0;
      if (run_len > RandomItems - items) run_len = RandomItems - items;
      if (run_len != 0) begin
        up = $urandom_range(0, 1);
        repeat (run_len) begin
          case ($urandom_range(0, 15))
            0:       pins = trk_pins;
            1:       pins = ~trk_pins;
            default: pins = gray_next(trk_pins, up);
          endcase
          send_request(OpPinSample, pins, 1'($urandom_range(0, 1)),
                       ChangeW'($urandom_range(0, 1023)), 1'b0, AllClear);
          items++;
          if (items >= CalmAfter) calm = 1'b1;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_request(OpW'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), ChangeW'($urandom_range(0, 1023)),
                       1'b0, AllClear);
          items++;
          if (items >= CalmAfter) calm = 1'b1;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
